/* rtl/isr64_pkg.sv */
// Shared types and constants for the 64-bit integer square root block.
// Used by isr64_ctrl, isr64_dp and integer_square_root_64_top.
package isr64_pkg;

   localparam int VALUE_WIDTH           = 64;
   localparam int ROOT_WIDTH            = 32;
   localparam int OPERAND_WIDTH_DEFAULT = 64;

   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } cmd_type;

endpackage

/* rtl/isr64_dp.sv */
// Datapath of the square root block: restoring root, one bit per step.
// Depends on isr64_pkg; driven by commands from isr64_ctrl.
module isr64_dp
   import isr64_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  cmd_type                cmd,
   input  logic [VALUE_WIDTH-1:0] value,
   output logic [ROOT_WIDTH-1:0]  root
);

   localparam int RW    = (OPERAND_WIDTH + 1) / 2;
   localparam int PW    = 2 * RW;
   localparam int REM_W = RW + 2;

   logic [PW-1:0]            op_ff,   op_in;
   logic [REM_W-1:0]         rem_ff,  rem_in;
   logic [RW-1:0]            root_ff, root_in;
   logic [ROOT_WIDTH-1:0]    res_ff,  res_in;

   logic [OPERAND_WIDTH-1:0] operand;
   logic                     negative;
   logic [REM_W-1:0]         shifted;
   logic [REM_W-1:0]         trial;
   logic [REM_W-1:0]         diff;
   logic                     take;
   logic [RW:0]              root_ext;

   assign operand  = value[OPERAND_WIDTH-1:0];
   assign negative = operand[OPERAND_WIDTH-1];
   assign shifted  = {rem_ff[RW-1:0], op_ff[PW-1 -: 2]};
   assign trial    = {root_ff, 2'b01};
   assign diff     = shifted - trial;
   assign take     = (shifted >= trial);
   assign root_ext = {root_ff, take};

   always_comb begin
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      res_in  = res_ff;
      if (cmd.load) begin
         op_in   = negative ? '0 : PW'(operand);
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.step) begin
         op_in   = op_ff << 2;
         rem_in  = take ? diff : shifted;
         root_in = root_ext[RW-1:0];
      end
      if (cmd.publish) begin
         res_in = ROOT_WIDTH'(root_ff);
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      res_ff  <= res_in;
   end

   assign root = res_ff;

endmodule

/* rtl/isr64_ctrl.sv */
// Controller of the square root block: handshakes, step counter, result valid.
// Depends on isr64_pkg; issues commands to isr64_dp.
module isr64_ctrl
   import isr64_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam int RW    = (OPERAND_WIDTH + 1) / 2;
   localparam int CNT_W = $clog2(RW + 1);

   typedef enum logic {
      IDLE,
      BUSY
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic             valid_ff, valid_in;
   logic             slot_free;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(RW);
               state_in = BUSY;
            end
         end
         BUSY: begin
            if (cnt_ff != '0) begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff - 1'b1;
            end else if (slot_free) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* rtl/integer_square_root_64_top.sv */
// Top level of the 64-bit integer square root block.
// Depends on isr64_pkg, isr64_ctrl and isr64_dp.
//
// Usage:
//   req channel carries one signed operand per transaction; only the low
//   OPERAND_WIDTH bits count, read as two's complement. Zero or negative
//   operands give a root of zero.
//   rsp channel returns floor(sqrt(operand)) per transaction, in order.
//   Timing: an operand is taken while the controller is idle, then the
//   restoring loop in the datapath produces one root bit per cycle,
//   ceil(OPERAND_WIDTH/2) root bits (32 at the default), then the result
//   register is loaded once it is free, and rsp_tvalid rises with it. A
//   new operand is taken only after the previous result has been loaded.
//   A stalled receiver holds rsp_tvalid and rsp_tdata; the next operand is
//   still accepted and computed, and waits in the datapath until the
//   result register is free.
//   Reset (synchronous, active high) drops any transaction in flight and
//   returns the block to idle with rsp_tvalid low.
module integer_square_root_64_top
   import isr64_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_WIDTH-1:0] req_tdata,   // [63:0] value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ROOT_WIDTH-1:0]  rsp_tdata    // [31:0] root
);

   cmd_type cmd;

   isr64_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd)
   );

   isr64_dp #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_dp (
      .clock(clock),
      .cmd  (cmd),
      .value(req_tdata),
      .root (rsp_tdata)
   );

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("controller still ready after loading an operand");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_tvalid)
      else $error("published result not presented");

   a_publish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

   a_rise_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.publish))
      else $error("rsp_tvalid raised without a publish");

endmodule

/* tb/integer_square_root_64_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for integer_square_root_64_top: drives signed operands, predicts
// floor square roots with a restoring bit-serial model and checks every rsp transaction.
// Depends on isr64_pkg and the integer_square_root_64_top RTL.
module integer_square_root_64_top_tb;
   import isr64_pkg::*;

   localparam int OPERAND_WIDTH  = OPERAND_WIDTH_DEFAULT;
   localparam int ROOT_LATENCY   = (OPERAND_WIDTH + 1) / 2 + 2;
   localparam int SETTLE_CYCLES  = 2 * ROOT_LATENCY;
   localparam int STALL_LIMIT    = 4000;
   localparam int RANDOM_PER_MIX = 380;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata  = '0;   // [63:0] value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [ROOT_WIDTH-1:0]  rsp_tdata;         // [31:0] root

   logic [ROOT_WIDTH-1:0]  expected_roots[$];
   logic [ROOT_WIDTH-1:0]  oldest_root;
   int                     sender_idle_pct   = 0;
   int                     receiver_idle_pct = 0;
   int                     operands_sent     = 0;
   int                     roots_checked     = 0;
   int                     mismatch_count    = 0;
   int                     quiet_cycles      = 0;

   integer_square_root_64_top #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ROOT_WIDTH-1:0] floor_sqrt(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] operand;
      logic [VALUE_WIDTH-1:0] remainder;
      logic [VALUE_WIDTH-1:0] partial;
      logic [VALUE_WIDTH-1:0] probe;
      operand = value & ({VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - OPERAND_WIDTH));
      if (operand == '0 || operand[OPERAND_WIDTH-1])
         return '0;
      remainder = operand;
      partial   = '0;
      probe     = 64'd1 << (2 * ((OPERAND_WIDTH + 1) / 2) - 2);
      for (int i = 0; i < (OPERAND_WIDTH + 1) / 2; i++) begin
         if (remainder >= partial + probe) begin
            remainder = remainder - (partial + probe);
            partial   = (partial >> 1) + probe;
         end else begin
            partial = partial >> 1;
         end
         probe = probe >> 2;
      end
      return partial[ROOT_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_operand();
      logic [VALUE_WIDTH-1:0] root_pick;
      logic [VALUE_WIDTH-1:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1: return raw;
         2, 3: begin
            root_pick = VALUE_WIDTH'($urandom_range(32'd3037000499));
            return root_pick * root_pick + VALUE_WIDTH'($urandom_range(2)) - 64'd1;
         end
         4, 5: return {1'b0, raw[62:0]} >> $urandom_range(62, 1);
         6:    return {1'b1, raw[62:0]};
         7:    return VALUE_WIDTH'($urandom_range(1000));
         default: return {1'b0, raw[62:0]};
      endcase
   endfunction

   task automatic send_operand(input logic [VALUE_WIDTH-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_roots.push_back(floor_sqrt(value));
      operands_sent++;
   endtask

   task automatic wait_for_roots();
      req_tvalid <= 1'b0;
      while (expected_roots.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_corners();
      logic [VALUE_WIDTH-1:0] corners[$];
      corners = '{64'h0, 64'h1, 64'h2, 64'h3, 64'h4, 64'd15, 64'd16, 64'd17,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'd9223372030926249001, 64'd9223372030926249000,
                  64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
                  64'h3FFF_FFFF_0000_0001, 64'h0000_0001_0000_0000,
                  64'h0000_0000_FFFF_FFFF, 64'h5555_5555_5555_5555,
                  64'hAAAA_AAAA_AAAA_AAAA};
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      foreach (corners[i])
         send_operand(corners[i]);
      wait_for_roots();
   endtask

   task automatic test_random_operands(input int send_idle, input int recv_idle);
      sender_idle_pct   = send_idle;
      receiver_idle_pct = recv_idle;
      repeat (RANDOM_PER_MIX)
         send_operand(random_operand());
   endtask

   task automatic test_drained_bursts();
      sender_idle_pct   = 16;
      receiver_idle_pct = 62;
      repeat (4) begin
         repeat ($urandom_range(25, 10))
            send_operand(random_operand());
         wait_for_roots();
      end
   endtask

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_roots.size() == 0) begin
            $error("unexpected root transaction: root %0d", rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_root = expected_roots.pop_front();
            roots_checked++;
            if (rsp_tdata !== oldest_root) begin
               $error("root mismatch: expected %0d, actual %0d", oldest_root, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("integer_square_root_64_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_random_operands(16, 62);
      test_drained_bursts();
      test_random_operands(62, 16);
      test_random_operands(0, 0);
      wait_for_roots();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered corner operands, random signed operands and perfect squares");
      $display("under mixed back-pressure: %0d operands sent, %0d roots checked",
               operands_sent, roots_checked);
      if (mismatch_count == 0 && expected_roots.size() == 0) begin
         $display("integer_square_root_64_top test passed");
      end else begin
         $display("integer_square_root_64_top test failed");
      end
      $finish;
   end

endmodule
